### rtl/sem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants of the sobel edge magnitude block
// widths, reset values, register map and the controller/datapath interface
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int HEIGHT_LIMIT      = 4096;

  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = 12;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  // gray weights, sum scaled by 32
  localparam int GRAY_R = 11;
  localparam int GRAY_G = 16;
  localparam int GRAY_B = 5;

  localparam int GRAD_W = 10;
  localparam int SQ_W   = 21;
  localparam int ROOT_W = 16;
  localparam logic [ROOT_W-2:0] ROOT_TOP = 15'h4000;
  localparam logic [PIX_W-1:0]  MAG_MAX  = 8'hFF;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
    logic square;
    logic root_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic has_result;
    logic root_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/sem_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sem_ctrl: sequencer of the sobel edge magnitude block
// runs the line store clearing pass, then walks each pixel through the datapath
// ----------------------------------------------------------------------------
module sem_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sem_pkg::dp_status_t  status_i,
  output sem_pkg::dp_cmd_t     cmd_o
);
  import sem_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_ROOT,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        // border pixels only update the stores
        state_d = status_i.has_result ? ST_SQUARE : ST_IDLE;
      end
      ST_SQUARE: begin
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (status_i.root_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign cmd_o.clear      = (state_q == ST_CLEAR);
  assign cmd_o.accept     = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.update     = (state_q == ST_READ);
  assign cmd_o.square     = (state_q == ST_SQUARE);
  assign cmd_o.root_step  = (state_q == ST_ROOT);
  assign cmd_o.load_out   = (state_q == ST_DONE) && status_i.out_free;

endmodule
`default_nettype wire

### rtl/sem_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sem_dp: datapath of the sobel edge magnitude block
// gray conversion, line store, 3x3 window, gradients, iterative square root
// ----------------------------------------------------------------------------
module sem_dp #(
  parameter int MAX_WIDTH = sem_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sem_pkg::dp_cmd_t              cmd_i,
  output sem_pkg::dp_status_t           status_o,
  input  logic [sem_pkg::WIDTH_W-1:0]   image_width_i,
  input  logic [sem_pkg::HEIGHT_W-1:0]  image_height_i,
  input  logic [sem_pkg::PIX_W-1:0]     red_i,
  input  logic [sem_pkg::PIX_W-1:0]     green_i,
  input  logic [sem_pkg::PIX_W-1:0]     blue_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [sem_pkg::PIX_W-1:0]     magnitude_o,
  output logic                          frame_end_o
);
  import sem_pkg::*;

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int CW     = (AW + 1 > WIDTH_W) ? AW + 1 : WIDTH_W;
  localparam int GSUM_W = 2 * PIX_W - 3;
  localparam int LINE_W = 2 * PIX_W;

  // control state
  logic [AW-1:0]    clr_addr_q;
  logic [AW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  logic             out_valid_q;

  // payload
  logic [AW-1:0]      addr_q;
  logic [PIX_W-1:0]   gray_q;
  logic               has_res_q;
  logic               last_q;
  logic               frame_end_q;
  logic [LINE_W-1:0]  rd_q;
  logic [PIX_W-1:0]   win_q [6];
  logic [GRAD_W-1:0]  gx_q, gy_q;
  logic [ROOT_W-1:0]  rem_q, res_q;
  logic [ROOT_W-2:0]  bit_q;
  logic               sat_q;
  logic [PIX_W-1:0]   mag_q;

  // line store: upper row in the high byte, middle row in the low byte
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];

  // size limits and position
  logic [CW-1:0]       w_ext, w_lim;
  logic [HEIGHT_W-1:0] h_lim;
  logic                row_end, frame_last;

  assign w_ext = CW'(image_width_i);
  assign w_lim = (w_ext < CW'(3)) ? CW'(3) :
                 (w_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_ext;
  assign h_lim = (image_height_i < HEIGHT_W'(3)) ? HEIGHT_W'(3) :
                 (image_height_i > HEIGHT_W'(HEIGHT_LIMIT)) ? HEIGHT_W'(HEIGHT_LIMIT) :
                 image_height_i;
  assign row_end    = CW'(col_q) >= (w_lim - CW'(1));
  assign frame_last = row_end && (HEIGHT_W'(row_q) >= (h_lim - HEIGHT_W'(1)));

  // gray value
  logic [GSUM_W-1:0] gray_sum;
  assign gray_sum = GSUM_W'(GRAY_R) * GSUM_W'(red_i)
                  + GSUM_W'(GRAY_G) * GSUM_W'(green_i)
                  + GSUM_W'(GRAY_B) * GSUM_W'(blue_i);

  // window sums, right column is top, mid and the new gray
  logic [PIX_W-1:0]  top, mid;
  logic [GRAD_W-1:0] lpos, rpos, upos, dpos;

  assign top  = rd_q[LINE_W-1:PIX_W];
  assign mid  = rd_q[PIX_W-1:0];
  assign lpos = GRAD_W'(win_q[0]) + {1'b0, win_q[1], 1'b0} + GRAD_W'(win_q[2]);
  assign rpos = GRAD_W'(top) + {1'b0, mid, 1'b0} + GRAD_W'(gray_q);
  assign upos = GRAD_W'(win_q[0]) + {1'b0, win_q[3], 1'b0} + GRAD_W'(top);
  assign dpos = GRAD_W'(win_q[2]) + {1'b0, win_q[5], 1'b0} + GRAD_W'(gray_q);

  // sum of squares
  logic [SQ_W-1:0] sq_sum;
  assign sq_sum = SQ_W'(gx_q) * SQ_W'(gx_q) + SQ_W'(gy_q) * SQ_W'(gy_q);

  // one step of the restoring square root
  logic [ROOT_W:0] trial;
  logic            take;
  assign trial = {1'b0, res_q} + {2'b00, bit_q};
  assign take  = {1'b0, rem_q} >= trial;

  // memory
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [LINE_W-1:0] mem_wd;

  assign mem_we = cmd_i.clear || cmd_i.update;
  assign mem_wa = cmd_i.clear ? clr_addr_q : addr_q;
  assign mem_wd = cmd_i.clear ? '0 : {mid, gray_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.accept) begin
      rd_q <= line_mem[col_q];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cmd_i.accept) begin
        col_q <= row_end ? '0 : col_q + AW'(1);
        if (row_end) begin
          row_q <= frame_last ? '0 : row_q + ROW_W'(1);
        end
      end
      if (cmd_i.update) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= gray_q;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q    <= col_q;
      gray_q    <= gray_sum[GSUM_W-1:5];
      has_res_q <= (row_q >= ROW_W'(2)) && (col_q >= AW'(2));
      last_q    <= frame_last;
    end
    if (cmd_i.update) begin
      gx_q <= (rpos >= lpos) ? rpos - lpos : lpos - rpos;
      gy_q <= (dpos >= upos) ? dpos - upos : upos - dpos;
    end
    if (cmd_i.square) begin
      rem_q <= sq_sum[ROOT_W-1:0];
      sat_q <= |sq_sum[SQ_W-1:ROOT_W];
      res_q <= '0;
      bit_q <= ROOT_TOP;
    end else if (cmd_i.root_step) begin
      if (take) begin
        rem_q <= rem_q - trial[ROOT_W-1:0];
        res_q <= (res_q >> 1) + ROOT_W'(bit_q);
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.load_out) begin
      mag_q       <= sat_q ? MAG_MAX : res_q[PIX_W-1:0];
      frame_end_q <= last_q;
    end
  end

  assign status_o.clr_last   = (clr_addr_q == AW'(MAX_WIDTH - 1));
  assign status_o.has_result = has_res_q;
  assign status_o.root_last  = bit_q[0];
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;
  assign frame_end_o = frame_end_q;

endmodule
`default_nettype wire

### rtl/sobel_edge_magnitude.sv
// a pixel is taken one at a time: once it is accepted, the controller passes
// the read state and, for interior pixels, the square, root and done states;
// the 8-step square root runs in the root state, and the output stall can hold done
// reset: a clearing pass zeroes every line store entry, pixels
// are stalled meanwhile while register writes are taken
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_magnitude: 3x3 sobel gradient magnitude over an rgb pixel stream
// apb register port, pixel input channel and saturated magnitude output
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = sem_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sem_pkg::PIX_W-1:0]     red_i,
  input  logic [sem_pkg::PIX_W-1:0]     green_i,
  input  logic [sem_pkg::PIX_W-1:0]     blue_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sem_pkg::PIX_W-1:0]     magnitude_o,
  output logic                          frame_end_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sem_pkg::PADDR_W-1:0]   paddr,
  input  logic [sem_pkg::DATA_W-1:0]    pwdata,
  output logic [sem_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import sem_pkg::*;

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic                cfg_we;
  reg_idx_e            reg_idx;

  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  width_q  <= pwdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(width_q);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(height_q);
      default:          prdata = '0;
    endcase
  end

  dp_cmd_t    cmd;
  dp_status_t status;

  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sem_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .magnitude_o    (magnitude_o),
    .frame_end_o    (frame_end_o)
  );

`ifndef SYNTHESIS
  // one pixel at a time: stall goes up right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("pixel accepted while previous pixel in flight");

  // a result is only loaded while the controller is busy with a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a pixel in flight");

  // width register takes the written data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && !paddr[2]) |=> (width_q == $past(pwdata[WIDTH_W-1:0])))
    else $error("width register write lost");
`endif

endmodule
`default_nettype wire
